// ===== rtl/core/tach_pkg.sv =====
package tach_pkg;

  // value fields and arithmetic unit sizes
  localparam int VAL_W = 40;
  localparam int DEN_W = 40;
  localparam int DIV_W = 50;
  localparam int MAC_W = 29;
  localparam int MAC_H = 42;
  localparam int MAC_P = MAC_H + MAC_W;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIAMETER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd4;

  // opcodes and status codes
  localparam logic OP_WINDOW = 1'b0;
  localparam logic OP_PERIOD = 1'b1;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // conversion constants
  localparam int FREQ_WIN_MUL = 1000;
  localparam int RPM_WIN_MUL = 60000;
  localparam int FREQ_PER_NUM = 1000000;
  localparam int RPM_PER_NUM = 60000000;
  localparam int ONE_Q16 = 65536;
  localparam int EMA_ROUND = 32768;
  localparam int EMA_SHIFT = 16;
  // pi in Q2.16 over 600 * 2^16, reduced by the common factor 3
  localparam int PI_DIV3 = 68629;
  localparam int SPEED_ROUND = 6553600;
  localparam int SPEED_SHIFT = 19;
  localparam int CM_DIV = 25;
  localparam int KM_MUL = 9;
  localparam int KM_ROUND = 125;
  localparam int KM_DIV = 250;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [MAC_W-1:0] ma;
    logic [MAC_W-1:0] mb;
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [MAC_H-1:0] init;
  } mac_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MAC_P-1:0] product;
  } mac_rsp_t;

  // clamp a quotient to the 40-bit output range
  function automatic logic [VAL_W-1:0] sat_val(input logic [DIV_W-1:0] v);
    return (|v[DIV_W-1:VAL_W]) ? VAL_MAX : v[VAL_W-1:0];
  endfunction

endpackage

// ===== rtl/core/wheel_speed_ema_tachometer.sv =====
// Wheel tachometer with a smoothed RPM reading.
// Input channel (in_valid / in_stall): one event per transaction, either a
// window pulse count (opcode 0) or a single pulse period (opcode 1), with the
// current time in ms. Output channel (out_valid / out_stall): one result per
// event with status, stationary flag, frequency, averaged RPM and speeds, all
// values unsigned fixed point with FRAC_BITS fraction bits, saturating.
// Configuration registers are written through cfg_we / cfg_index / cfg_data;
// the user must do so only while no event is in flight, which is not enforced.
// One event is in flight at a time: a new event is taken only after the last
// result has moved to the output register. The work is done by the bit-serial
// divider (four divisions: frequency, raw RPM, cm/s, km/h) and the bit-serial
// multiplier (two passes: average, speed); an invalid event runs only the
// speed pass and the cm/s and km/h divisions.
// The result sits in an output register: a stalled receiver holds it steady,
// and the next event is taken meanwhile but its result waits for that slot.
// Synchronous reset restores the default registers and clears the average,
// the sample flag, the stored frequency and the last pulse time.
module wheel_speed_ema_tachometer #(
  parameter int FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [15:0]                       pulse_count,
  input  logic [31:0]                       interval_us,
  input  logic [31:0]                       now_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              status,
  output logic                              stationary,
  output logic [tach_pkg::VAL_W-1:0]        frequency_hz,
  output logic [tach_pkg::VAL_W-1:0]        rpm_average,
  output logic [tach_pkg::VAL_W-1:0]        speed_cm_per_s,
  output logic [tach_pkg::VAL_W-1:0]        speed_km_per_h,
  input  logic                              cfg_we,
  input  logic [tach_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tach_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_FREQ_DEN, S_FREQ_NUM, S_FREQ_RUN, S_RAW_DEN, S_RAW_NUM, S_RAW_RUN,
    S_EMA_SET, S_EMA_RUN, S_SPD_SET, S_SPD_RUN, S_CM_RUN, S_KM_RUN, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [7:0]  magnet_count;
  logic [11:0] wheel_diameter_mm;
  logic [16:0] smoothing_weight;
  logic [15:0] window_length_ms;
  logic [15:0] idle_timeout_ms;

  // latched event
  logic        opcode_r;
  logic [15:0] pulses_r;
  logic [31:0] interval_r;
  logic [31:0] now_r;

  // tachometer state
  logic [tach_pkg::VAL_W-1:0] rpm_store;
  logic                       have_sample;
  logic [31:0]                last_pulse_time;
  logic [tach_pkg::VAL_W-1:0] frequency_store;

  // working registers
  logic                       status_r;
  logic                       stationary_r;
  logic                       idle_r;
  logic                       sample_r;
  logic [31:0]                base_r;
  logic [tach_pkg::DEN_W-1:0] den_r;
  logic [tach_pkg::VAL_W-1:0] raw_r;
  logic [tach_pkg::VAL_W-1:0] cm_r;
  logic [tach_pkg::VAL_W-1:0] km_r;

  tach_pkg::div_req_t div_req;
  tach_pkg::div_rsp_t div_rsp;
  tach_pkg::mac_req_t mac_req;
  tach_pkg::mac_rsp_t mac_rsp;

  // combinational helpers
  logic                       is_window;
  logic                       bad;
  logic [31:0]                den_base;
  logic [tach_pkg::DEN_W-1:0] raw_den;
  logic [31:0]                freq_base;
  logic [31:0]                rpm_base;
  logic [tach_pkg::DIV_W-1:0] num_next;
  logic [16:0]                w_clip;
  logic [31:0]                elapsed;
  logic                       idle_hit;
  logic                       sample;
  logic [16:0]                w_eff;
  logic [16:0]                w_rest;
  logic                       use_raw;
  logic [tach_pkg::VAL_W-1:0] ema_val;
  logic [tach_pkg::MAC_W-1:0] spd_k;
  logic [tach_pkg::DIV_W-1:0] km_num;
  logic                       out_free;

  tach_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tach_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mac_req),
    .rsp (mac_rsp)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // argument check and divider operands
  always_comb begin
    is_window = (opcode_r == tach_pkg::OP_WINDOW);
    bad = (magnet_count == '0) ||
          (is_window ? (window_length_ms == '0) : (interval_r == '0));
    den_base = is_window ? 32'(window_length_ms) : interval_r;
    raw_den = tach_pkg::DEN_W'(den_base) * tach_pkg::DEN_W'(magnet_count);
    freq_base = is_window ? 32'(pulses_r) * 32'(tach_pkg::FREQ_WIN_MUL)
                          : 32'(tach_pkg::FREQ_PER_NUM);
    rpm_base = is_window ? 32'(pulses_r) * 32'(tach_pkg::RPM_WIN_MUL)
                         : 32'(tach_pkg::RPM_PER_NUM);
    // numerator plus half the divisor gives round to nearest
    num_next = (tach_pkg::DIV_W'(base_r) << FRAC_BITS) + tach_pkg::DIV_W'(den_r >> 1);
  end

  // average update selection
  always_comb begin
    w_clip = (smoothing_weight > 17'(tach_pkg::ONE_Q16)) ? 17'(tach_pkg::ONE_Q16)
                                                          : smoothing_weight;
    elapsed  = now_r - last_pulse_time;
    idle_hit = is_window && (pulses_r == '0) && (elapsed > 32'(idle_timeout_ms));
    sample   = !is_window || (pulses_r != '0);
    if (idle_hit) begin
      // full weight on zero clears the average
      w_eff   = 17'(tach_pkg::ONE_Q16);
      use_raw = 1'b0;
    end else if (sample) begin
      w_eff   = have_sample ? w_clip : 17'(tach_pkg::ONE_Q16);
      use_raw = 1'b1;
    end else if (have_sample) begin
      // empty window decays toward zero
      w_eff   = w_clip;
      use_raw = 1'b0;
    end else begin
      w_eff   = '0;
      use_raw = 1'b0;
    end
    w_rest = 17'(tach_pkg::ONE_Q16) - w_eff;
    ema_val = (|mac_rsp.product[tach_pkg::MAC_P-1:tach_pkg::VAL_W+tach_pkg::EMA_SHIFT])
              ? tach_pkg::VAL_MAX
              : mac_rsp.product[tach_pkg::VAL_W+tach_pkg::EMA_SHIFT-1:tach_pkg::EMA_SHIFT];
  end

  // speed operands
  always_comb begin
    spd_k  = tach_pkg::MAC_W'(wheel_diameter_mm) * tach_pkg::MAC_W'(tach_pkg::PI_DIV3);
    km_num = (div_rsp.quo << 3) + div_rsp.quo + tach_pkg::DIV_W'(tach_pkg::KM_ROUND);
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      div_req.start     <= 1'b0;
      mac_req.start     <= 1'b0;
      magnet_count      <= 8'd1;
      wheel_diameter_mm <= 12'd660;
      smoothing_weight  <= 17'd16384;
      window_length_ms  <= 16'd100;
      idle_timeout_ms   <= 16'd1000;
      rpm_store         <= '0;
      have_sample       <= 1'b0;
      last_pulse_time   <= '0;
      frequency_store   <= '0;
    end else begin
      div_req.start <= 1'b0;
      mac_req.start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          tach_pkg::REG_MAGNET:   magnet_count      <= cfg_data[7:0];
          tach_pkg::REG_DIAMETER: wheel_diameter_mm <= cfg_data[11:0];
          tach_pkg::REG_WEIGHT:   smoothing_weight  <= cfg_data;
          tach_pkg::REG_WINDOW:   window_length_ms  <= cfg_data[15:0];
          tach_pkg::REG_TIMEOUT:  idle_timeout_ms   <= cfg_data[15:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            opcode_r   <= opcode;
            pulses_r   <= pulse_count;
            interval_r <= interval_us;
            now_r      <= now_ms;
            state      <= S_FREQ_DEN;
          end
        end
        S_FREQ_DEN: begin
          status_r     <= bad ? tach_pkg::STATUS_INVALID : tach_pkg::STATUS_OK;
          stationary_r <= 1'b0;
          den_r        <= tach_pkg::DEN_W'(den_base);
          base_r       <= freq_base;
          // invalid transaction only reports the stored values
          state        <= bad ? S_SPD_SET : S_FREQ_NUM;
        end
        S_FREQ_NUM: begin
          div_req.start <= 1'b1;
          div_req.num   <= num_next;
          div_req.den   <= den_r;
          state         <= S_FREQ_RUN;
        end
        S_FREQ_RUN: begin
          if (div_rsp.done) begin
            frequency_store <= tach_pkg::sat_val(div_rsp.quo);
            state           <= S_RAW_DEN;
          end
        end
        S_RAW_DEN: begin
          den_r  <= raw_den;
          base_r <= rpm_base;
          state  <= S_RAW_NUM;
        end
        S_RAW_NUM: begin
          div_req.start <= 1'b1;
          div_req.num   <= num_next;
          div_req.den   <= den_r;
          state         <= S_RAW_RUN;
        end
        S_RAW_RUN: begin
          if (div_rsp.done) begin
            raw_r <= tach_pkg::sat_val(div_rsp.quo);
            state <= S_EMA_SET;
          end
        end
        S_EMA_SET: begin
          if (sample) begin
            last_pulse_time <= now_r;
          end
          stationary_r  <= idle_hit;
          idle_r        <= idle_hit;
          sample_r      <= sample;
          mac_req.start <= 1'b1;
          mac_req.ma    <= tach_pkg::MAC_W'(w_eff);
          mac_req.mb    <= tach_pkg::MAC_W'(w_rest);
          mac_req.x     <= use_raw ? raw_r : '0;
          mac_req.y     <= rpm_store;
          mac_req.init  <= tach_pkg::MAC_H'(tach_pkg::EMA_ROUND);
          state         <= S_EMA_RUN;
        end
        S_EMA_RUN: begin
          if (mac_rsp.done) begin
            rpm_store <= ema_val;
            if (idle_r) begin
              have_sample <= 1'b0;
            end else if (sample_r) begin
              have_sample <= 1'b1;
            end
            state <= S_SPD_SET;
          end
        end
        S_SPD_SET: begin
          mac_req.start <= 1'b1;
          mac_req.ma    <= spd_k;
          mac_req.mb    <= '0;
          mac_req.x     <= rpm_store;
          mac_req.y     <= '0;
          mac_req.init  <= tach_pkg::MAC_H'(tach_pkg::SPEED_ROUND);
          state         <= S_SPD_RUN;
        end
        S_SPD_RUN: begin
          if (mac_rsp.done) begin
            div_req.start <= 1'b1;
            div_req.num   <= mac_rsp.product[tach_pkg::SPEED_SHIFT +: tach_pkg::DIV_W];
            div_req.den   <= tach_pkg::DEN_W'(tach_pkg::CM_DIV);
            state         <= S_CM_RUN;
          end
        end
        S_CM_RUN: begin
          if (div_rsp.done) begin
            // km/h works from the unclamped cm/s quotient
            cm_r          <= tach_pkg::sat_val(div_rsp.quo);
            div_req.start <= 1'b1;
            div_req.num   <= km_num;
            div_req.den   <= tach_pkg::DEN_W'(tach_pkg::KM_DIV);
            state         <= S_KM_RUN;
          end
        end
        S_KM_RUN: begin
          if (div_rsp.done) begin
            km_r  <= tach_pkg::sat_val(div_rsp.quo);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= status_r;
            stationary     <= stationary_r;
            frequency_hz   <= frequency_store;
            rpm_average    <= rpm_store;
            speed_cm_per_s <= cm_r;
            speed_km_per_h <= km_r;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(div_rsp.busy && mac_rsp.busy))
    else $error("divider and multiplier busy together");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_average_cleared: assert property (@(posedge clk) disable iff (rst)
    !have_sample |-> (rpm_store == '0))
    else $error("average nonzero without a sample");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the final step");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction taken while one is in flight");

endmodule

// ===== rtl/core/tach_div.sv =====
module tach_div (
  input  logic               clk,
  input  logic               rst,
  input  tach_pkg::div_req_t req,
  output tach_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(tach_pkg::DIV_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(tach_pkg::DIV_W - 1);

  logic                         busy;
  logic                         done;
  logic [CNT_W-1:0]             cnt;
  logic [tach_pkg::DIV_W-1:0]   nq;
  logic [tach_pkg::DEN_W-1:0]   rem;
  logic [tach_pkg::DEN_W-1:0]   den;
  logic [tach_pkg::DEN_W:0]     trial;
  logic [tach_pkg::DEN_W:0]     diff;
  logic                         ge;

  // one quotient bit per cycle, restoring step
  always_comb begin
    trial = {rem, nq[tach_pkg::DIV_W-1]};
    diff  = trial - {1'b0, den};
    ge    = trial >= {1'b0, den};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (req.start) begin
      nq  <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (busy) begin
      nq  <= {nq[tach_pkg::DIV_W-2:0], ge};
      rem <= ge ? diff[tach_pkg::DEN_W-1:0] : trial[tach_pkg::DEN_W-1:0];
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = nq;

endmodule

// ===== rtl/core/tach_mac.sv =====
module tach_mac (
  input  logic               clk,
  input  logic               rst,
  input  tach_pkg::mac_req_t req,
  output tach_pkg::mac_rsp_t rsp
);

  localparam int CNT_W = $clog2(tach_pkg::MAC_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(tach_pkg::MAC_W - 1);

  logic                         busy;
  logic                         done;
  logic [CNT_W-1:0]             cnt;
  logic [tach_pkg::MAC_W-1:0]   ma;
  logic [tach_pkg::MAC_W-1:0]   mb;
  logic [tach_pkg::VAL_W-1:0]   x;
  logic [tach_pkg::VAL_W-1:0]   y;
  logic [tach_pkg::MAC_H-1:0]   h;
  logic [tach_pkg::MAC_W-1:0]   l;
  logic [tach_pkg::VAL_W-1:0]   add_x;
  logic [tach_pkg::VAL_W-1:0]   add_y;
  logic [tach_pkg::MAC_H:0]     s;

  // add the selected multiplicands for the current multiplier bits
  always_comb begin
    add_x = ma[0] ? x : '0;
    add_y = mb[0] ? y : '0;
    s = {1'b0, h} + (tach_pkg::MAC_H+1)'(add_x) + (tach_pkg::MAC_H+1)'(add_y);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-right accumulator, the preset lands at bit zero of the product
  always_ff @(posedge clk) begin
    if (req.start) begin
      ma <= req.ma;
      mb <= req.mb;
      x  <= req.x;
      y  <= req.y;
      h  <= req.init;
      l  <= '0;
    end else if (busy) begin
      ma <= ma >> 1;
      mb <= mb >> 1;
      h  <= s[tach_pkg::MAC_H:1];
      l  <= {s[0], l[tach_pkg::MAC_W-1:1]};
    end
  end

  assign rsp.busy    = busy;
  assign rsp.done    = done;
  assign rsp.product = {h, l};

endmodule

// ===== tb/wheel_speed_ema_tachometer_tb.sv =====
`timescale 1ns / 1ps

module wheel_speed_ema_tachometer_tb;
  import tach_pkg::*;

  localparam int FRAC = 8;
  localparam int CYCLE_LIMIT = 2_500_000;
  localparam int LONG_HOLD = 2000;
  localparam int DRAIN_CYCLES = 300;

  typedef logic [127:0] wide_t;

  localparam wide_t UNITY_Q16 = 65536;
  localparam wide_t HALF_Q16 = 32768;
  localparam wide_t PI_Q2_16 = 205887;

  typedef struct packed {
    logic        opcode;
    logic [15:0] pulse_count;
    logic [31:0] interval_us;
    logic [31:0] now_ms;
  } tach_evt_t;

  typedef struct packed {
    logic             status;
    logic             stationary;
    logic [VAL_W-1:0] frequency_hz;
    logic [VAL_W-1:0] rpm_average;
    logic [VAL_W-1:0] speed_cm_per_s;
    logic [VAL_W-1:0] speed_km_per_h;
  } tach_reading_t;

  typedef struct packed {
    logic [7:0]  magnets;
    logic [11:0] diameter;
    logic [16:0] weight;
    logic [15:0] window;
    logic [15:0] timeout;
  } tach_setup_t;

  // block ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  opcode = OP_WINDOW;
  logic [15:0]           pulse_count = '0;
  logic [31:0]           interval_us = '0;
  logic [31:0]           now_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  status;
  logic                  stationary;
  logic [VAL_W-1:0]      frequency_hz;
  logic [VAL_W-1:0]      rpm_average;
  logic [VAL_W-1:0]      speed_cm_per_s;
  logic [VAL_W-1:0]      speed_km_per_h;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of registers and state
  logic [7:0]       magnets_cfg = 8'd1;
  logic [11:0]      diameter_cfg = 12'd660;
  logic [16:0]      weight_cfg = 17'd16384;
  logic [15:0]      window_cfg = 16'd100;
  logic [15:0]      timeout_cfg = 16'd1000;
  logic [VAL_W-1:0] rpm_avg = '0;
  logic             avg_valid = 1'b0;
  logic [31:0]      last_pulse_ms = '0;
  logic [VAL_W-1:0] freq_hold = '0;

  // stimulus and checking bookkeeping
  tach_evt_t     evt_backlog[$];
  tach_reading_t expected_readings[$];
  tach_evt_t     cur_evt = '0;
  logic [31:0]   clock_ms = '0;
  int            n_queued = 0;
  int            n_accepted = 0;
  int            n_checked = 0;
  int            n_window = 0;
  int            n_period = 0;
  int            n_invalid = 0;
  int            n_idle_clear = 0;
  int            n_setups = 0;
  int            fail_count = 0;
  int            cycle_count = 0;
  int            send_wait = 0;
  int            send_run = 0;
  bit            send_calm = 1'b0;
  int            recv_wait = 0;
  int            recv_run = 0;
  bit            recv_calm = 1'b0;
  logic          hold_req = 1'b0;
  int            hold_left = 0;

  wheel_speed_ema_tachometer #(
    .FRAC_BITS(FRAC)
  ) i_dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round to nearest, halves up
  function automatic wide_t div_round(wide_t a, wide_t b, wide_t c);
    return (a * b + c / 2) / c;
  endfunction

  function automatic logic [VAL_W-1:0] clamp40(wide_t x);
    return (x > wide_t'(VAL_MAX)) ? VAL_MAX : x[VAL_W-1:0];
  endfunction

  // surface speed from the averaged rpm; km/h uses the unclamped cm/s
  function automatic tach_reading_t with_speeds(tach_reading_t r);
    wide_t cm;
    cm = div_round(wide_t'(r.rpm_average) * wide_t'(diameter_cfg), PI_Q2_16, 600 * UNITY_Q16);
    r.speed_cm_per_s = clamp40(cm);
    r.speed_km_per_h = clamp40(div_round(cm, 9, 250));
    return r;
  endfunction

  // expected reading for one event, advancing the predictor state
  function automatic tach_reading_t compute_reading(tach_evt_t ev);
    tach_reading_t r;
    wide_t         w;
    wide_t         raw;
    wide_t         scale;
    wide_t         old_avg;
    logic          bad;
    logic [31:0]   idle_ms;
    scale = wide_t'(1) << FRAC;
    w = (weight_cfg > 17'd65536) ? UNITY_Q16 : wide_t'(weight_cfg);
    old_avg = wide_t'(rpm_avg);
    bad = (magnets_cfg == 8'd0) ||
          ((ev.opcode == OP_WINDOW) ? (window_cfg == 16'd0) : (ev.interval_us == 32'd0));
    r = '0;
    r.status = STATUS_OK;
    if (ev.opcode == OP_WINDOW) n_window++;
    else n_period++;

    // rejected event: report stored values, state untouched
    if (bad) begin
      n_invalid++;
      r.status = STATUS_INVALID;
      r.frequency_hz = freq_hold;
      r.rpm_average = rpm_avg;
      return with_speeds(r);
    end

    if (ev.opcode == OP_WINDOW) begin
      freq_hold = clamp40(div_round(wide_t'(ev.pulse_count) * 1000, scale,
                                    wide_t'(window_cfg)));
      raw = wide_t'(clamp40(div_round(wide_t'(ev.pulse_count) * 60000, scale,
                                      wide_t'(window_cfg) * wide_t'(magnets_cfg))));
      if (ev.pulse_count != 16'd0) last_pulse_ms = ev.now_ms;
      idle_ms = ev.now_ms - last_pulse_ms;
      // idle too long: average and first-sample flag cleared
      if (idle_ms > {16'd0, timeout_cfg}) begin
        n_idle_clear++;
        rpm_avg = '0;
        avg_valid = 1'b0;
        r.stationary = 1'b1;
        r.frequency_hz = freq_hold;
        return r;
      end
      if (ev.pulse_count != 16'd0) begin
        if (!avg_valid) rpm_avg = raw[VAL_W-1:0];
        else rpm_avg = clamp40((w * raw + (UNITY_Q16 - w) * old_avg + HALF_Q16) >> 16);
        avg_valid = 1'b1;
      end else if (avg_valid) begin
        // empty window decays toward zero
        rpm_avg = clamp40(((UNITY_Q16 - w) * old_avg + HALF_Q16) >> 16);
      end
    end else begin
      freq_hold = clamp40(div_round(1000000, scale, wide_t'(ev.interval_us)));
      raw = wide_t'(clamp40(div_round(60000000, scale,
                                      wide_t'(ev.interval_us) * wide_t'(magnets_cfg))));
      last_pulse_ms = ev.now_ms;
      if (!avg_valid) rpm_avg = raw[VAL_W-1:0];
      else rpm_avg = clamp40((w * raw + (UNITY_Q16 - w) * old_avg + HALF_Q16) >> 16);
      avg_valid = 1'b1;
    end

    r.frequency_hz = freq_hold;
    r.rpm_average = rpm_avg;
    return with_speeds(r);
  endfunction

  // per-transaction wait, in stretches that are either idle-free or random
  function automatic int draw_wait(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 40);
      calm = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic tach_evt_t evt(logic op, logic [15:0] pulses, logic [31:0] period,
                                    logic [31:0] stamp);
    tach_evt_t ev;
    ev.opcode = op;
    ev.pulse_count = pulses;
    ev.interval_us = period;
    ev.now_ms = stamp;
    return ev;
  endfunction

  function automatic tach_setup_t setup(logic [7:0] m, logic [11:0] d, logic [16:0] w,
                                        logic [15:0] win, logic [15:0] t);
    tach_setup_t s;
    s.magnets = m;
    s.diameter = d;
    s.weight = w;
    s.window = win;
    s.timeout = t;
    return s;
  endfunction

  function automatic tach_setup_t random_setup();
    return setup(8'($urandom_range(1, 255)), 12'($urandom_range(0, 4095)),
                 17'($urandom_range(0, 131071)),
                 16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                  : $urandom_range(1, 500)),
                 16'($urandom_range(0, 65535)));
  endfunction

  // mostly a running clock with plausible counts, some quiet gaps, some noise
  function automatic tach_evt_t make_event();
    tach_evt_t ev;
    int        pick;
    pick = $urandom_range(0, 99);
    ev.opcode = ($urandom_range(0, 2) == 0) ? OP_PERIOD : OP_WINDOW;
    case ($urandom_range(0, 7))
      0, 1: ev.pulse_count = 16'd0;
      6: ev.pulse_count = 16'($urandom());
      7: ev.pulse_count = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF;
      default: ev.pulse_count = 16'($urandom_range(1, 300));
    endcase
    case ($urandom_range(0, 7))
      6: ev.interval_us = $urandom();
      7: ev.interval_us = $urandom_range(0, 20);
      default: ev.interval_us = $urandom_range(500, 200000);
    endcase
    if (pick < 75) begin
      clock_ms += (ev.opcode == OP_WINDOW && window_cfg != 16'd0) ? 32'(window_cfg)
                                                                 : $urandom_range(0, 50);
      ev.now_ms = clock_ms;
    end else if (pick < 88) begin
      // empty window after a gap around the idle limit
      clock_ms += $urandom_range(0, 2 * timeout_cfg + 2);
      ev.opcode = OP_WINDOW;
      ev.pulse_count = 16'd0;
      ev.now_ms = clock_ms;
    end else begin
      ev.now_ms = $urandom();
    end
    return ev;
  endfunction

  task automatic enqueue(tach_evt_t ev);
    evt_backlog.push_back(ev);
    n_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
  endtask

  // write all registers while idle, mirror them in the predictor
  task automatic program_regs(tach_setup_t s);
    write_reg(REG_MAGNET, CFG_DATA_W'(s.magnets));
    write_reg(REG_DIAMETER, CFG_DATA_W'(s.diameter));
    write_reg(REG_WEIGHT, CFG_DATA_W'(s.weight));
    write_reg(REG_WINDOW, CFG_DATA_W'(s.window));
    write_reg(REG_TIMEOUT, CFG_DATA_W'(s.timeout));
    @(posedge clk);
    cfg_we <= 1'b0;
    magnets_cfg = s.magnets;
    diameter_cfg = s.diameter;
    weight_cfg = s.weight;
    window_cfg = s.window;
    timeout_cfg = s.timeout;
    n_setups++;
    @(negedge clk);
  endtask

  // wait until every queued event is taken and every reading has come back
  task automatic settle();
    do @(negedge clk);
    while (n_accepted != n_queued || expected_readings.size() != 0);
  endtask

  task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // input driver: one transaction per event, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_readings.push_back(compute_reading(cur_evt));
        n_accepted++;
        send_wait = draw_wait(send_run, send_calm);
      end
      if (in_valid && in_stall) begin
        // payload held while stalled
      end else if (send_wait != 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (evt_backlog.size() != 0) begin
        cur_evt = evt_backlog.pop_front();
        opcode <= cur_evt.opcode;
        pulse_count <= cur_evt.pulse_count;
        interval_us <= cur_evt.interval_us;
        now_ms <= cur_evt.now_ms;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output monitor: compare each transaction with the oldest expected reading
  always @(posedge clk) begin
    tach_reading_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected reading, expected none, actual status %0d rpm %0d",
                   $time, status, rpm_average);
        end else begin
          want = expected_readings.pop_front();
          check_field("status", VAL_W'(want.status), VAL_W'(status));
          check_field("stationary", VAL_W'(want.stationary), VAL_W'(stationary));
          check_field("frequency_hz", want.frequency_hz, frequency_hz);
          check_field("rpm_average", want.rpm_average, rpm_average);
          check_field("speed_cm_per_s", want.speed_cm_per_s, speed_cm_per_s);
          check_field("speed_km_per_h", want.speed_km_per_h, speed_km_per_h);
          n_checked++;
        end
        recv_wait = draw_wait(recv_run, recv_calm);
      end else if (out_valid && recv_wait != 0) begin
        recv_wait--;
      end
      out_stall <= (hold_left != 0) || (recv_wait != 0);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("wheel_speed_ema_tachometer regression: fail");
      $finish;
    end
  end

  initial begin
    tach_setup_t plan[8];
    int          plan_items[8];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: first sample, averaging, decay, timeout boundary, extremes, wrap
    program_regs(setup(8'd1, 12'd660, 17'd16384, 16'd100, 16'd1000));
    enqueue(evt(OP_WINDOW, 16'd10, 32'd0, 32'd100));
    enqueue(evt(OP_WINDOW, 16'd20, 32'd0, 32'd200));
    enqueue(evt(OP_WINDOW, 16'd0, 32'd0, 32'd300));
    enqueue(evt(OP_WINDOW, 16'd0, 32'd0, 32'd1200));
    enqueue(evt(OP_WINDOW, 16'd0, 32'd0, 32'd1201));
    enqueue(evt(OP_WINDOW, 16'd0, 32'd0, 32'd1300));
    enqueue(evt(OP_PERIOD, 16'd0, 32'd1, 32'd1400));
    enqueue(evt(OP_PERIOD, 16'hFFFF, 32'hFFFF_FFFF, 32'd1500));
    enqueue(evt(OP_PERIOD, 16'd0, 32'd0, 32'd1600));
    enqueue(evt(OP_WINDOW, 16'hFFFF, 32'hFFFF_FFFF, 32'd1700));
    enqueue(evt(OP_WINDOW, 16'd1, 32'd0, 32'hFFFF_FFFF));
    enqueue(evt(OP_WINDOW, 16'd0, 32'd0, 32'd5));
    settle();

    // zero magnet count rejects both kinds of event
    program_regs(setup(8'd0, 12'd660, 17'd16384, 16'd100, 16'd1000));
    enqueue(evt(OP_WINDOW, 16'd5, 32'd0, 32'd100));
    enqueue(evt(OP_PERIOD, 16'd0, 32'd1000, 32'd200));
    settle();

    // shortest window, full weight, zero timeout, largest wheel
    program_regs(setup(8'd1, 12'd4095, 17'd65536, 16'd1, 16'd0));
    enqueue(evt(OP_WINDOW, 16'hFFFF, 32'd0, 32'd10));
    enqueue(evt(OP_PERIOD, 16'd0, 32'd1, 32'd11));
    enqueue(evt(OP_WINDOW, 16'd0, 32'd0, 32'd11));
    enqueue(evt(OP_WINDOW, 16'd0, 32'd0, 32'd12));
    settle();

    // zero window rejects window mode only; weight above one is clamped
    program_regs(setup(8'd255, 12'd0, 17'd131071, 16'd0, 16'd65535));
    enqueue(evt(OP_WINDOW, 16'd3, 32'd0, 32'd20));
    enqueue(evt(OP_PERIOD, 16'd0, 32'd7, 32'd21));
    enqueue(evt(OP_PERIOD, 16'd0, 32'd3, 32'd22));
    enqueue(evt(OP_WINDOW, 16'd0, 32'd0, 32'd23));

    // random phases over a spread of register settings
    plan[0] = setup(8'd1, 12'd660, 17'd16384, 16'd100, 16'd1000);
    plan[1] = setup(8'd4, 12'd700, 17'd8192, 16'd250, 16'd2000);
    plan[2] = setup(8'd255, 12'd4095, 17'd65535, 16'd65535, 16'd65535);
    plan[3] = setup(8'd1, 12'd1, 17'd1, 16'd1, 16'd0);
    plan[4] = setup(8'd0, 12'd660, 17'd16384, 16'd100, 16'd1000);
    plan[5] = random_setup();
    plan[6] = setup(8'd2, 12'd2000, 17'd0, 16'd50, 16'd300);
    plan[7] = random_setup();
    plan_items = '{240, 240, 200, 200, 60, 240, 200, 240};
    clock_ms = 32'd1000;
    for (int p = 0; p < 8; p++) begin
      settle();
      program_regs(plan[p]);
      // run the clock across the 32-bit wrap
      if (p == 2) clock_ms = 32'hFFFF_F000;
      for (int k = 0; k < plan_items[p]; k++) enqueue(make_event());
      if (p == 1) begin
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d readings checked: %0d window, %0d period, %0d rejected, %0d idle clears",
             n_checked, n_window, n_period, n_invalid, n_idle_clear);
    $display("%0d register setups, a long output hold-off and a time wrap", n_setups);
    if (fail_count == 0) begin
      $display("wheel_speed_ema_tachometer regression: pass");
    end else begin
      $display("wheel_speed_ema_tachometer regression: fail");
    end
    $finish;
  end

endmodule
